// ===== sv/assert_macros.svh =====
// Assertion macros shared by the priority queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define SPQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property at every clock edge, reset included.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== sv/spq_pkg.sv =====
// Shared constants, codes and control types of the sorted priority queue.
`default_nettype none
package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMD_W    = 2;
   localparam int STS_W    = 2;
   localparam int VAL_W    = 32;
   localparam int PRI_W    = 16;
   localparam int RCNT_W   = 5;

   localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

   localparam logic [STS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STS_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_PUSH,
      OP_POP,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      logic              capture;
      logic              exec;
      op_type            op;
      logic              sel_head;
      logic [STS_W-1:0]  status;
   } ctl_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic              empty;
      logic              full;
   } sts_type;

endpackage
`default_nettype wire

// ===== sv/spq_datapath.sv =====
// Compare-and-shift entry array, request capture and response registers.
`default_nettype none
`include "assert_macros.svh"
module spq_datapath
   import spq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [CMD_W-1:0]         req_command,
   input  wire logic signed [VAL_W-1:0]  req_value,
   input  wire logic signed [PRI_W-1:0]  req_priority_req,
   input  wire ctl_type                  ctl,
   output sts_type                       sts,
   output logic [STS_W-1:0]              rsp_status,
   output logic signed [VAL_W-1:0]       rsp_value_res,
   output logic [RCNT_W-1:0]             rsp_count
);

   logic [CMD_W-1:0]         cmd_ff;
   logic signed [VAL_W-1:0]  value_ff;
   logic signed [PRI_W-1:0]  pri_ff;
   logic [CNT_W-1:0]         occ_ff, occ_in;
   logic signed [VAL_W-1:0]  slot_val_ff [CAPACITY];
   logic signed [PRI_W-1:0]  slot_pri_ff [CAPACITY];
   logic [CAPACITY-1:0]      le;
   logic [STS_W-1:0]         status_ff;
   logic signed [VAL_W-1:0]  res_ff;
   logic [RCNT_W-1:0]        count_ff;

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         le[i] = (CNT_W'(i) < occ_ff) && (slot_pri_ff[i] <= pri_ff);
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (ctl.exec) begin
         case (ctl.op)
            OP_PUSH:  occ_in = occ_ff + CNT_W'(1);
            OP_POP:   occ_in = occ_ff - CNT_W'(1);
            OP_CLEAR: occ_in = '0;
            default:  occ_in = occ_ff;
         endcase
      end
   end

   assign sts.command = cmd_ff;
   assign sts.empty   = (occ_ff == '0);
   assign sts.full    = (occ_ff == CNT_W'(CAPACITY));

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff   <= req_command;
         value_ff <= req_value;
         pri_ff   <= req_priority_req;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (ctl.op == OP_PUSH && !le[i]) begin
               if (i == 0) begin
                  slot_val_ff[i] <= value_ff;
                  slot_pri_ff[i] <= pri_ff;
               end else if (le[i-1]) begin
                  slot_val_ff[i] <= value_ff;
                  slot_pri_ff[i] <= pri_ff;
               end else begin
                  slot_val_ff[i] <= slot_val_ff[i-1];
                  slot_pri_ff[i] <= slot_pri_ff[i-1];
               end
            end else if (ctl.op == OP_POP && i < CAPACITY - 1) begin
               slot_val_ff[i] <= slot_val_ff[i+1];
               slot_pri_ff[i] <= slot_pri_ff[i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec) begin
         status_ff <= ctl.status;
         res_ff    <= ctl.sel_head ? slot_val_ff[0] : '0;
         count_ff  <= RCNT_W'(occ_in);
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_value_res = res_ff;
   assign rsp_count     = count_ff;

   `SPQ_ASSERT(a_occ_bound, occ_ff <= CNT_W'(CAPACITY), "occupancy above capacity")
   `SPQ_ASSERT(a_push_grows, ctl.exec && ctl.op == OP_PUSH |=> occ_ff == $past(occ_ff) + CNT_W'(1), "push did not add one entry")
   `SPQ_ASSERT(a_pop_nonempty, ctl.exec && ctl.op == OP_POP |-> !sts.empty, "pop issued on empty queue")

endmodule
`default_nettype wire

// ===== sv/spq_controller.sv =====
// Command sequencer: captures a request, then issues the array operation and result.
`default_nettype none
`include "assert_macros.svh"
module spq_controller
   import spq_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire sts_type  sts,
   output ctl_type       ctl,
   output logic          busy,
   output logic          rsp_strobe
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               strobe_ff <= 1'b0;
               if (start) state_ff <= S_EXEC;
            end
            S_EXEC: begin
               strobe_ff <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: begin
               strobe_ff <= 1'b0;
               state_ff  <= S_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      ctl          = '0;
      ctl.op       = OP_NONE;
      ctl.status   = ST_OK;
      ctl.capture  = (state_ff == S_IDLE) && start;
      ctl.exec     = (state_ff == S_EXEC);
      if (sts.command == CMD_PUSH) begin
         if (sts.full) begin
            ctl.status = ST_FULL;
         end else begin
            ctl.op = OP_PUSH;
         end
      end else if (sts.empty) begin
         ctl.status = ST_EMPTY;
      end else begin
         unique case (sts.command)
            CMD_POP: begin
               ctl.op       = OP_POP;
               ctl.sel_head = 1'b1;
            end
            CMD_PEEK:  ctl.sel_head = 1'b1;
            CMD_CLEAR: ctl.op       = OP_CLEAR;
            default:   ctl.op       = OP_NONE;
         endcase
      end
   end

   assign busy       = (state_ff == S_EXEC);
   assign rsp_strobe = strobe_ff;

   `SPQ_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted word did not raise busy")
   `SPQ_ASSERT(a_busy_strobe, busy |=> rsp_strobe && !busy, "execute cycle gave no result")
   `SPQ_ASSERT(a_strobe_excl, !(busy && rsp_strobe), "result strobe during execute")
   `SPQ_ASSERT_ALWAYS(a_reset_idle, reset |=> !busy && !rsp_strobe, "reset left a word active")

endmodule
`default_nettype wire

// ===== sv/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: controller and entry array.
//
// A command word is taken at a rising edge where start is high and busy is
// low. Busy is then high for one cycle while the compare-and-shift array
// executes the command, and the result appears on the rsp_ ports for exactly
// one cycle, marked by rsp_strobe, in the cycle after that. Each command thus
// passes through the controller's capture and execute steps; a new
// word may be started in the cycle the result is shown. The receiver cannot
// stall, so it must take every result in its strobe cycle. The queue holds
// CAPACITY entries, lowest priority first, equal priorities in arrival order;
// a push on a full queue is rejected with status full.
`default_nettype none
module sorted_priority_queue
   import spq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [CMD_W-1:0]         req_command,
   input  wire logic signed [VAL_W-1:0]  req_value,
   input  wire logic signed [PRI_W-1:0]  req_priority_req,
   output logic                          rsp_strobe,
   output logic [STS_W-1:0]              rsp_status,
   output logic signed [VAL_W-1:0]       rsp_value_res,
   output logic [RCNT_W-1:0]             rsp_count
);

   ctl_type ctl;
   sts_type sts;

   spq_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .sts        (sts),
      .ctl        (ctl),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   spq_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_value        (req_value),
      .req_priority_req (req_priority_req),
      .ctl              (ctl),
      .sts              (sts),
      .rsp_status       (rsp_status),
      .rsp_value_res    (rsp_value_res),
      .rsp_count        (rsp_count)
   );

endmodule
`default_nettype wire

// ===== dv/sorted_priority_queue_test.sv =====
// Self-checking testbench of the sorted priority queue: command words against a predicted queue.
`timescale 1ns / 1ps
module sorted_priority_queue_test;
   import spq_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_LIMIT = 40;

   typedef struct {
      logic [CMD_W-1:0]        command;
      logic signed [VAL_W-1:0] value;
      logic signed [PRI_W-1:0] prio;
   } spq_word_type;

   typedef struct {
      logic [STS_W-1:0]        status;
      logic signed [VAL_W-1:0] value;
      logic [RCNT_W-1:0]       count;
   } spq_reply_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic [CMD_W-1:0]        req_command = CMD_PEEK;
   logic signed [VAL_W-1:0] req_value = '0;
   logic signed [PRI_W-1:0] req_priority_req = '0;
   logic                    busy;
   logic                    rsp_strobe;
   logic [STS_W-1:0]        rsp_status;
   logic signed [VAL_W-1:0] rsp_value_res;
   logic [RCNT_W-1:0]       rsp_count;

   spq_word_type  pending_words[$];
   spq_reply_type expected_replies[$];

   logic signed [VAL_W-1:0] held_value[CAPACITY];
   logic signed [PRI_W-1:0] held_prio[CAPACITY];
   int held_count = 0;

   int idle_pct = 21;
   bit word_taken = 1'b0;
   int words_queued = 0;
   int words_accepted = 0;
   int replies_checked = 0;
   int error_count = 0;
   int cycle_count = 0;
   int full_rejects = 0;
   int empty_reports = 0;
   int heads_served = 0;
   int full_hits = 0;

   sorted_priority_queue u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_value        (req_value),
      .req_priority_req (req_priority_req),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_value_res    (rsp_value_res),
      .rsp_count        (rsp_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      error_count++;
   endtask

   function automatic spq_reply_type queue_apply(input spq_word_type w);
      spq_reply_type r;
      int pos;
      r.status = ST_OK;
      r.value = '0;
      if (w.command == CMD_PUSH) begin
         if (held_count >= CAPACITY) begin
            r.status = ST_FULL;
            full_rejects++;
         end else begin
            pos = 0;
            while (pos < held_count && held_prio[pos] <= w.prio) pos++;
            for (int i = held_count; i > pos; i--) begin
               held_value[i] = held_value[i-1];
               held_prio[i] = held_prio[i-1];
            end
            held_value[pos] = w.value;
            held_prio[pos] = w.prio;
            held_count++;
            if (held_count == CAPACITY) full_hits++;
         end
      end else if (held_count == 0) begin
         r.status = ST_EMPTY;
         empty_reports++;
      end else if (w.command == CMD_POP) begin
         r.value = held_value[0];
         for (int i = 1; i < held_count; i++) begin
            held_value[i-1] = held_value[i];
            held_prio[i-1] = held_prio[i];
         end
         held_count--;
         heads_served++;
      end else if (w.command == CMD_PEEK) begin
         r.value = held_value[0];
         heads_served++;
      end else begin
         held_count = 0;
      end
      r.count = RCNT_W'(held_count);
      return r;
   endfunction

   task automatic add_word(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] val,
                           input logic signed [PRI_W-1:0] pri);
      spq_word_type w;
      w.command = cmd;
      w.value = val;
      w.prio = pri;
      pending_words.push_back(w);
      words_queued++;
   endtask

   task automatic add_random_words(input int n);
      int left;
      int burst;
      int mode;
      int p_push;
      int p_pop;
      int r;
      bit narrow;
      logic [CMD_W-1:0] cmd;
      logic signed [PRI_W-1:0] pri;
      left = n;
      while (left > 0) begin
         burst = $urandom_range(40, 8);
         mode = $urandom_range(2);
         narrow = 1'($urandom_range(1));
         p_push = (mode == 0) ? 75 : (mode == 1) ? 20 : 45;
         p_pop = (mode == 0) ? 15 : (mode == 1) ? 60 : 35;
         for (int k = 0; k < burst && left > 0; k++) begin
            r = $urandom_range(99);
            if (r < p_push) cmd = CMD_PUSH;
            else if (r < p_push + p_pop) cmd = CMD_POP;
            else if (r < 97) cmd = CMD_PEEK;
            else cmd = CMD_CLEAR;
            if ($urandom_range(15) == 0) pri = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            else if (narrow) pri = PRI_W'(int'($urandom_range(3)) - 2);
            else pri = PRI_W'($urandom);
            add_word(cmd, VAL_W'($urandom), pri);
            left--;
         end
      end
   endtask

   task automatic drain;
      while (words_accepted != words_queued || expected_replies.size() != 0) begin
         @(negedge clock);
      end
   endtask

   always @(negedge clock) begin
      spq_word_type w;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || word_taken) begin
         word_taken = 1'b0;
         if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
            w = pending_words.pop_front();
            req_command <= w.command;
            req_value <= w.value;
            req_priority_req <= w.prio;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      spq_reply_type exp_r;
      spq_word_type w;
      cycle_count++;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_replies.size() == 0) begin
               report_mismatch($sformatf("result with none expected: status %0d value %0d count %0d",
                                         rsp_status, rsp_value_res, rsp_count));
            end else begin
               exp_r = expected_replies.pop_front();
               replies_checked++;
               if (rsp_status !== exp_r.status)
                  report_mismatch($sformatf("reply %0d status %0d, expected %0d",
                                            replies_checked, rsp_status, exp_r.status));
               if (rsp_value_res !== exp_r.value)
                  report_mismatch($sformatf("reply %0d value %0d, expected %0d",
                                            replies_checked, rsp_value_res, exp_r.value));
               if (rsp_count !== exp_r.count)
                  report_mismatch($sformatf("reply %0d count %0d, expected %0d",
                                            replies_checked, rsp_count, exp_r.count));
            end
         end
         if (start && !busy) begin
            w.command = req_command;
            w.value = req_value;
            w.prio = req_priority_req;
            expected_replies.push_back(queue_apply(w));
            words_accepted++;
            word_taken = 1'b1;
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_word(CMD_CLEAR, 32'sd7, 16'sd3);
      add_word(CMD_POP, 32'sd9, -16'sd1);
      add_word(CMD_PEEK, 32'sd11, 16'sd0);
      add_word(CMD_PUSH, 32'sh7fffffff, 16'sd0);
      add_word(CMD_PUSH, 32'sh80000000, 16'sd0);
      add_word(CMD_PUSH, 32'sd0, 16'sh8000);
      add_word(CMD_PUSH, -32'sd1, 16'sh7fff);
      add_word(CMD_PUSH, 32'sd5, 16'sd0);
      for (int i = 0; i < 11; i++) begin
         add_word(CMD_PUSH, VAL_W'($urandom), PRI_W'((i % 3) - 1));
      end
      add_word(CMD_PUSH, 32'sh5a5a5a5a, 16'sh8000);
      add_word(CMD_PEEK, 32'sd0, 16'sd0);
      add_word(CMD_POP, 32'sd0, 16'sd0);
      add_word(CMD_CLEAR, 32'sd0, 16'sd0);
      add_word(CMD_POP, 32'sd0, 16'sd0);
      drain();

      add_random_words(609);
      drain();
      idle_pct = 65;
      add_random_words(609);
      drain();
      idle_pct = 0;
      add_random_words(609);
      drain();
      repeat (10) @(posedge clock);

      if (expected_replies.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_replies.size()));
      $display("Ran %0d command words, %0d results compared; queue filled %0d times.",
               words_accepted, replies_checked, full_hits);
      $display("Saw %0d full rejects, %0d empty reports, %0d head reads.",
               full_rejects, empty_reports, heads_served);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
